/* hdl/event_grouping_reorder_table_top_macros.svh */
// Assertion macros for the event grouping reorder table.
// Used by the controller and the top level; needs clk and rst_n in scope.
`ifndef EVENT_GROUPING_REORDER_TABLE_TOP_MACROS_SVH
`define EVENT_GROUPING_REORDER_TABLE_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define EGRT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication checked in the cycle after the antecedent
`define EGRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* hdl/egrt_pkg.sv */
// Package for the event grouping reorder table: commands, status codes, states.
// No dependencies.
package egrt_pkg;
    localparam int SLOTS_DEFAULT = 64;
    localparam logic [15:0] TIMEOUT_RESET = 16'd2;
    localparam logic [7:0] COUNT_MAX = 8'd255;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_FETCH = 2'd1,
        CMD_TERMINATE = 2'd2,
        CMD_COMPLETE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_APPENDED = 3'd0,
        ST_NEW = 3'd1,
        ST_EOE_DROP = 3'd2,
        ST_FULL = 3'd3,
        ST_RELEASED = 3'd4,
        ST_NONE = 3'd5,
        ST_DONE = 3'd6,
        ST_UNUSED = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        SL_EMPTY = 2'd0,
        SL_BUILDING = 2'd1,
        SL_COMPLETE = 2'd2,
        SL_SPARE = 2'd3
    } slot_state_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_SCAN_WAIT,
        FSM_WRITE,
        FSM_SWEEP,
        FSM_SWEEP_WAIT,
        FSM_OUT
    } fsm_t;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture request
        logic clear;  // reset scan index
        logic step;   // issue read at scan index, advance
        logic write;  // commit add/fetch result
        logic sweep;  // issue completion-sweep read
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;     // scan index at final slot
    } dp_stat_t;
endpackage

/* hdl/egrt_if.sv */
// Valid/ready channel interface used by all ports of the table.
// Depends on nothing; payload type is a parameter.
interface egrt_if #(parameter type T = logic) (input logic clk);
    logic valid;
    logic ready;
    T payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* hdl/egrt_ctrl.sv */
// Controller of the table: sequences scan, write, sweep and output phases.
// Depends on egrt_pkg.
`include "event_grouping_reorder_table_top_macros.svh"
module egrt_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  logic need_sweep,
    output egrt_pkg::dp_cmd_t cmd,
    input  egrt_pkg::dp_stat_t stat
);
    import egrt_pkg::*;

    fsm_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= FSM_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            FSM_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cmd.clear = 1'b1;
                    state_next = FSM_SCAN;
                end
            end
            FSM_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.last)
                    state_next = FSM_SCAN_WAIT;
            end
            FSM_SCAN_WAIT:
                state_next = FSM_WRITE;
            FSM_WRITE:
            begin
                cmd.write = 1'b1;
                cmd.clear = 1'b1;
                state_next = need_sweep ? FSM_SWEEP : FSM_OUT;
            end
            FSM_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (stat.last)
                    state_next = FSM_SWEEP_WAIT;
            end
            FSM_SWEEP_WAIT:
                state_next = FSM_OUT;
            FSM_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = FSM_IDLE;
            end
            default:
                state_next = FSM_IDLE;
        endcase
    end

    `EGRT_ASSERT_IMP(a_ready_idle, in_ready, !out_valid, "accept while result pending")
    `EGRT_ASSERT_NEXT(a_load_scan, cmd.load, state_reg == FSM_SCAN, "load did not start scan")
    `EGRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
endmodule

/* hdl/egrt_dp.sv */
// Datapath of the table: slot memory, state flags, scan index and result.
// Depends on egrt_pkg.
module egrt_dp #(
    parameter int SLOTS = egrt_pkg::SLOTS_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_valid,
    input  logic [15:0] cfg_data,
    input  logic [1:0] cmd_in,
    input  logic [31:0] rec_seconds,
    input  logic [9:0] rec_millis,
    input  logic [31:0] rec_serial,
    input  logic [15:0] rec_node,
    input  logic rec_is_final,
    input  logic rec_is_eoe,
    input  logic rec_enriched,
    input  egrt_pkg::dp_cmd_t cmd,
    output egrt_pkg::dp_stat_t stat,
    output logic need_sweep,
    output logic [2:0] status,
    output logic [5:0] slot_index,
    output logic [31:0] ev_seconds,
    output logic [9:0] ev_millis,
    output logic [31:0] ev_serial,
    output logic [15:0] ev_node,
    output logic [7:0] ev_records,
    output logic ev_enriched,
    output logic [6:0] ready_events
);
    import egrt_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef struct packed {
        logic [31:0] sec;
        logic [9:0] ms;
        logic [31:0] ser;
        logic [15:0] node;
        logic first_final;
        logic any_final;
        logic enr;
        logic [7:0] cnt;
    } entry_t;

    entry_t mem [SLOTS];
    entry_t rd_reg;
    logic [1:0] st_reg [SLOTS];
    logic [15:0] timeout_reg;
    logic [CW-1:0] ready_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] rd_idx_reg;
    logic rd_vld_reg;
    logic [1:0] rd_st_reg;

    // request capture
    logic [1:0] c_cmd_reg;
    logic [31:0] c_sec_reg;
    logic [9:0] c_ms_reg;
    logic [31:0] c_ser_reg;
    logic [15:0] c_node_reg;
    logic c_fin_reg, c_eoe_reg, c_enr_reg;

    // scan results
    logic match_reg, empty_reg, best_reg;
    logic [IW-1:0] match_idx_reg, empty_idx_reg, best_idx_reg;
    entry_t match_e_reg, best_e_reg;
    logic [1:0] best_st_reg;

    logic [2:0] status_reg;
    logic [5:0] sidx_reg;
    entry_t ev_reg;
    logic ev_vld_reg;

    // marks sweep reads (set at write, cleared at next load)
    logic swp_reg;

    logic key_eq, later;
    assign key_eq = rd_st_reg == SL_BUILDING && rd_reg.sec == c_sec_reg
        && rd_reg.ms == c_ms_reg && rd_reg.ser == c_ser_reg && rd_reg.node == c_node_reg;
    // best strictly later than current read
    always_comb
    begin
        priority if (best_e_reg.sec != rd_reg.sec)
            later = best_e_reg.sec > rd_reg.sec;
        else if (best_e_reg.ms != rd_reg.ms)
            later = best_e_reg.ms > rd_reg.ms;
        else
            later = best_e_reg.ser > rd_reg.ser;
    end

    logic [32:0] deadline;
    assign deadline = {1'b0, rd_reg.sec} + {17'd0, timeout_reg};
    logic timed;
    assign timed = deadline <= {1'b0, c_sec_reg} || rd_reg.first_final;

    logic is_add;
    assign is_add = c_cmd_reg == CMD_ADD;
    assign need_sweep = is_add && !match_reg && !c_eoe_reg;
    assign stat.last = idx_reg == IW'(SLOTS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= TIMEOUT_RESET;
        else if (cfg_valid)
            timeout_reg <= cfg_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            c_cmd_reg <= cmd_in;
            c_sec_reg <= rec_seconds;
            c_ms_reg <= rec_millis;
            c_ser_reg <= rec_serial;
            c_node_reg <= rec_node;
            c_fin_reg <= rec_is_final;
            c_eoe_reg <= rec_is_eoe;
            c_enr_reg <= rec_enriched;
        end
        if (cmd.step || cmd.sweep)
        begin
            rd_reg <= mem[idx_reg];
            rd_idx_reg <= idx_reg;
        end
        if (cmd.write)
        begin
            if (is_add && match_reg)
            begin
                mem[match_idx_reg] <= '{sec: match_e_reg.sec, ms: match_e_reg.ms,
                    ser: match_e_reg.ser, node: match_e_reg.node,
                    first_final: match_e_reg.first_final,
                    any_final: match_e_reg.any_final | c_fin_reg,
                    enr: match_e_reg.enr | c_enr_reg,
                    cnt: (match_e_reg.cnt == COUNT_MAX) ? COUNT_MAX
                        : match_e_reg.cnt + 8'd1};
            end
            else if (is_add && !c_eoe_reg && empty_reg)
            begin
                mem[empty_idx_reg] <= '{sec: c_sec_reg, ms: c_ms_reg, ser: c_ser_reg,
                    node: c_node_reg, first_final: c_fin_reg, any_final: c_fin_reg,
                    enr: c_enr_reg, cnt: 8'd1};
            end
        end
        if (cmd.write)
            ev_reg <= best_e_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                st_reg[i] <= SL_EMPTY;
            ready_reg <= '0;
            idx_reg <= '0;
            rd_vld_reg <= 1'b0;
            rd_st_reg <= SL_EMPTY;
            match_reg <= 1'b0;
            empty_reg <= 1'b0;
            best_reg <= 1'b0;
            match_idx_reg <= '0;
            empty_idx_reg <= '0;
            best_idx_reg <= '0;
            best_st_reg <= SL_EMPTY;
            match_e_reg <= '0;
            best_e_reg <= '0;
            status_reg <= ST_DONE;
            sidx_reg <= '0;
            ev_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.step || cmd.sweep;
            if (cmd.step || cmd.sweep)
                rd_st_reg <= st_reg[idx_reg];
            if (cmd.clear)
                idx_reg <= '0;
            else if (cmd.step || cmd.sweep)
                idx_reg <= idx_reg + IW'(1);
            if (cmd.load)
            begin
                match_reg <= 1'b0;
                empty_reg <= 1'b0;
                best_reg <= 1'b0;
            end
            // scan phase evaluation
            if (rd_vld_reg && !cmd.sweep && !(cmd.write) && c_cmd_reg != CMD_TERMINATE
                && c_cmd_reg != CMD_COMPLETE && !swp_reg)
            begin
                if (!match_reg && key_eq)
                begin
                    match_reg <= 1'b1;
                    match_idx_reg <= rd_idx_reg;
                    match_e_reg <= rd_reg;
                end
                if (!empty_reg && rd_st_reg == SL_EMPTY)
                begin
                    empty_reg <= 1'b1;
                    empty_idx_reg <= rd_idx_reg;
                end
                if (rd_st_reg != SL_EMPTY && (!best_reg || later))
                begin
                    best_reg <= 1'b1;
                    best_idx_reg <= rd_idx_reg;
                    best_st_reg <= rd_st_reg;
                    best_e_reg <= rd_reg;
                end
            end
            // terminate/complete-all, one slot per scan cycle
            if (rd_vld_reg && !swp_reg && (c_cmd_reg == CMD_TERMINATE
                || c_cmd_reg == CMD_COMPLETE) && rd_st_reg == SL_BUILDING
                && (c_cmd_reg == CMD_TERMINATE || rd_reg.any_final))
            begin
                st_reg[rd_idx_reg] <= SL_COMPLETE;
                ready_reg <= ready_reg + CW'(1);
            end
            // timeout sweep after new event or full
            if (rd_vld_reg && swp_reg && rd_st_reg == SL_BUILDING && timed)
            begin
                st_reg[rd_idx_reg] <= SL_COMPLETE;
                ready_reg <= ready_reg + CW'(1);
            end
            if (cmd.write)
            begin
                sidx_reg <= '0;
                ev_vld_reg <= 1'b0;
                unique case (c_cmd_reg)
                    CMD_ADD:
                    begin
                        if (match_reg)
                        begin
                            status_reg <= ST_APPENDED;
                            sidx_reg <= 6'(match_idx_reg);
                        end
                        else if (c_eoe_reg)
                            status_reg <= ST_EOE_DROP;
                        else if (empty_reg)
                        begin
                            status_reg <= ST_NEW;
                            sidx_reg <= 6'(empty_idx_reg);
                            st_reg[empty_idx_reg] <= SL_BUILDING;
                        end
                        else
                            status_reg <= ST_FULL;
                    end
                    CMD_FETCH:
                    begin
                        if (ready_reg != '0 && best_reg && best_st_reg == SL_COMPLETE)
                        begin
                            status_reg <= ST_RELEASED;
                            sidx_reg <= 6'(best_idx_reg);
                            st_reg[best_idx_reg] <= SL_EMPTY;
                            ready_reg <= ready_reg - CW'(1);
                            ev_vld_reg <= 1'b1;
                        end
                        else
                            status_reg <= ST_NONE;
                    end
                    default:
                        status_reg <= ST_DONE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            swp_reg <= 1'b0;
        else if (cmd.load)
            swp_reg <= 1'b0;
        else if (cmd.write)
            swp_reg <= need_sweep;
    end

    assign status = status_reg;
    assign slot_index = sidx_reg;
    assign ev_seconds = ev_vld_reg ? ev_reg.sec : '0;
    assign ev_millis = ev_vld_reg ? ev_reg.ms : '0;
    assign ev_serial = ev_vld_reg ? ev_reg.ser : '0;
    assign ev_node = ev_vld_reg ? ev_reg.node : '0;
    assign ev_records = ev_vld_reg ? ev_reg.cnt : '0;
    assign ev_enriched = ev_vld_reg ? ev_reg.enr : 1'b0;
    assign ready_events = (ready_reg > CW'(127)) ? 7'd127 : 7'(ready_reg);
endmodule

/* hdl/event_grouping_reorder_table_top.sv */
// Top level of the event grouping reorder table: channels, controller, datapath.
// Depends on egrt_pkg, egrt_if, egrt_ctrl and egrt_dp.
//
// Use: requests arrive on the in channel (cmd plus record key and flags);
// each request gives exactly one result on the out channel (status, slot,
// released event fields, count of ready events). The cfg channel writes the
// 16-bit end timeout; write it only while the block is idle.
// Fetch, append, eoe drop and the all-commands scan every slot once; a new
// event or a full table adds a timeout sweep over every slot after the write.
// The scan runs through the single-port slot memory, read one slot a cycle.
// One request is in flight at a time; in.ready is high only when idle.
// Reset empties every slot, zeroes the ready count and sets the timeout to 2;
// no clearing pass is needed. A stalled receiver holds the result steady and
// keeps the next request waiting.
`include "event_grouping_reorder_table_top_macros.svh"
module event_grouping_reorder_table_top #(
    parameter int SLOTS = egrt_pkg::SLOTS_DEFAULT
) (
    input logic clk,
    input logic rst_n,
    egrt_if.sink cfg,
    egrt_if.sink in,
    egrt_if.source out
);
    import egrt_pkg::*;

    dp_cmd_t dcmd;
    dp_stat_t dstat;
    logic need_sweep;

    assign cfg.ready = 1'b1;

    egrt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in.valid), .in_ready(in.ready),
        .out_valid(out.valid), .out_ready(out.ready),
        .need_sweep(need_sweep), .cmd(dcmd), .stat(dstat)
    );

    egrt_dp #(.SLOTS(SLOTS)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg.valid), .cfg_data(cfg.payload.end_timeout_seconds),
        .cmd_in(in.payload.cmd), .rec_seconds(in.payload.rec_seconds),
        .rec_millis(in.payload.rec_millis), .rec_serial(in.payload.rec_serial),
        .rec_node(in.payload.rec_node), .rec_is_final(in.payload.rec_is_final),
        .rec_is_eoe(in.payload.rec_is_eoe), .rec_enriched(in.payload.rec_enriched),
        .cmd(dcmd), .stat(dstat), .need_sweep(need_sweep),
        .status(out.payload.status), .slot_index(out.payload.slot_index),
        .ev_seconds(out.payload.ev_seconds), .ev_millis(out.payload.ev_millis),
        .ev_serial(out.payload.ev_serial), .ev_node(out.payload.ev_node),
        .ev_records(out.payload.ev_records), .ev_enriched(out.payload.ev_enriched),
        .ready_events(out.payload.ready_events)
    );

    `EGRT_ASSERT_IMP(a_one_flight, in.valid && in.ready, !out.valid, "overlap of requests")
    `EGRT_ASSERT_IMP(a_ready_cap, out.valid, out.payload.ready_events <= 7'd127, "ready count")
    `EGRT_ASSERT_IMP(a_status_range, out.valid, out.payload.status != ST_UNUSED, "bad status")
endmodule

/* test/event_grouping_reorder_table_top_tb.sv */
// Testbench for event_grouping_reorder_table_top: directed and random requests
// checked against an in-bench model of the slot table. Needs egrt_pkg and egrt_if.
`timescale 1ns / 1ps
module event_grouping_reorder_table_top_tb;
    import egrt_pkg::*;

    localparam int NSLOT = 64;
    localparam int TURNAROUND = 2 * NSLOT + 5;
    localparam longint CYCLE_LIMIT = 1000000;
    localparam int HOLD_LEN = 1500;

    typedef struct packed {
        logic [15:0] end_timeout_seconds;
    } timeout_word_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] rec_seconds;
        logic [9:0]  rec_millis;
        logic [31:0] rec_serial;
        logic [15:0] rec_node;
        logic        rec_is_final;
        logic        rec_is_eoe;
        logic        rec_enriched;
    } table_req_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  slot_index;
        logic [31:0] ev_seconds;
        logic [9:0]  ev_millis;
        logic [31:0] ev_serial;
        logic [15:0] ev_node;
        logic [7:0]  ev_records;
        logic        ev_enriched;
        logic [6:0]  ready_events;
    } table_res_t;

    class event_table_model;
        slot_state_t slot_st[NSLOT];
        logic [31:0] s_sec[NSLOT];
        logic [9:0]  s_ms[NSLOT];
        logic [31:0] s_ser[NSLOT];
        logic [15:0] s_node[NSLOT];
        logic        s_first_fin[NSLOT];
        logic        s_any_fin[NSLOT];
        logic        s_enr[NSLOT];
        logic [7:0]  s_cnt[NSLOT];
        int          ready_total;
        logic [15:0] end_timeout;
        table_res_t  pending_results[$];
        int          mismatches;
        int          results_seen;
        int          releases;
        int          fulls;

        function void clear();
            foreach (slot_st[i]) slot_st[i] = SL_EMPTY;
            ready_total = 0;
            end_timeout = TIMEOUT_RESET;
            mismatches = 0;
            results_seen = 0;
            releases = 0;
            fulls = 0;
        endfunction

        function bit is_later(int a, int b);
            if (s_sec[a] != s_sec[b]) return s_sec[a] > s_sec[b];
            if (s_ms[a] != s_ms[b]) return s_ms[a] > s_ms[b];
            return s_ser[a] > s_ser[b];
        endfunction

        function void sweep_timeouts(logic [31:0] now);
            for (int i = 0; i < NSLOT; i++)
            begin
                if (slot_st[i] == SL_BUILDING &&
                    (({1'b0, s_sec[i]} + {17'd0, end_timeout} <= {1'b0, now}) || s_first_fin[i]))
                begin
                    slot_st[i] = SL_COMPLETE;
                    ready_total++;
                end
            end
        endfunction

        function void note_request(table_req_t r);
            table_res_t e;
            int hit;
            e = '0;
            hit = -1;
            if (r.cmd == CMD_ADD)
            begin
                for (int i = 0; i < NSLOT && hit < 0; i++)
                    if (slot_st[i] == SL_BUILDING && s_sec[i] == r.rec_seconds &&
                        s_ms[i] == r.rec_millis && s_ser[i] == r.rec_serial &&
                        s_node[i] == r.rec_node)
                        hit = i;
                if (hit >= 0)
                begin
                    if (s_cnt[hit] != COUNT_MAX) s_cnt[hit]++;
                    s_enr[hit] |= r.rec_enriched;
                    s_any_fin[hit] |= r.rec_is_final;
                    e.status = ST_APPENDED;
                    e.slot_index = hit[5:0];
                end
                else if (r.rec_is_eoe)
                    e.status = ST_EOE_DROP;
                else
                begin
                    for (int i = 0; i < NSLOT && hit < 0; i++)
                        if (slot_st[i] == SL_EMPTY) hit = i;
                    if (hit >= 0)
                    begin
                        slot_st[hit] = SL_BUILDING;
                        s_sec[hit] = r.rec_seconds;
                        s_ms[hit] = r.rec_millis;
                        s_ser[hit] = r.rec_serial;
                        s_node[hit] = r.rec_node;
                        s_first_fin[hit] = r.rec_is_final;
                        s_any_fin[hit] = r.rec_is_final;
                        s_enr[hit] = r.rec_enriched;
                        s_cnt[hit] = 8'd1;
                        e.status = ST_NEW;
                        e.slot_index = hit[5:0];
                    end
                    else
                    begin
                        e.status = ST_FULL;
                        fulls++;
                    end
                    sweep_timeouts(r.rec_seconds);
                end
            end
            else if (r.cmd == CMD_FETCH)
            begin
                e.status = ST_NONE;
                if (ready_total != 0)
                begin
                    for (int i = 0; i < NSLOT; i++)
                        if (slot_st[i] != SL_EMPTY && (hit < 0 || is_later(hit, i)))
                            hit = i;
                    if (hit >= 0 && slot_st[hit] == SL_COMPLETE)
                    begin
                        slot_st[hit] = SL_EMPTY;
                        ready_total--;
                        releases++;
                        e.status = ST_RELEASED;
                        e.slot_index = hit[5:0];
                        e.ev_seconds = s_sec[hit];
                        e.ev_millis = s_ms[hit];
                        e.ev_serial = s_ser[hit];
                        e.ev_node = s_node[hit];
                        e.ev_records = s_cnt[hit];
                        e.ev_enriched = s_enr[hit];
                    end
                end
            end
            else
            begin
                for (int i = 0; i < NSLOT; i++)
                    if (slot_st[i] == SL_BUILDING && (r.cmd == CMD_TERMINATE || s_any_fin[i]))
                    begin
                        slot_st[i] = SL_COMPLETE;
                        ready_total++;
                    end
                e.status = ST_DONE;
            end
            e.ready_events = (ready_total > 127) ? 7'd127 : ready_total[6:0];
            pending_results.push_back(e);
        endfunction

        function void check_result(table_res_t got);
            table_res_t e;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            e = pending_results.pop_front();
            if (got !== e)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d differs\n  expected %p\n  actual   %p",
                             results_seen, e, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    event_table_model model;
    longint cycle_count;
    event hold_start;
    logic hold_off = 1'b0;
    int requests_sent;
    logic [31:0] now_sec;

    egrt_if #(.T(timeout_word_t)) cfg_ch (clk);
    egrt_if #(.T(table_req_t)) req_ch (clk);
    egrt_if #(.T(table_res_t)) res_ch (clk);

    event_grouping_reorder_table_top #(.SLOTS(NSLOT)) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_ch.sink),
        .in(req_ch.sink),
        .out(res_ch.source)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("event_grouping_reorder_table_top: mismatch");
            $finish;
        end
    end

    // long receiver hold-off, counted here once triggered
    always
    begin
        @(hold_start);
        hold_off <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_off <= 1'b0;
    end

    // receiver: random back-pressure with periodic always-ready windows, plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (hold_off)
            res_ch.ready <= 1'b0;
        else if (cycle_count % 3000 < 600)
            res_ch.ready <= 1'b1;
        else
            res_ch.ready <= ($urandom_range(0, 9) < 7);
    end

    always @(posedge clk)
        if (rst_n && res_ch.valid && res_ch.ready)
            model.check_result(res_ch.payload);

    task automatic send_request(table_req_t r, int gap);
        req_ch.valid <= 1'b1;
        req_ch.payload <= r;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        model.note_request(r);
        requests_sent++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (model.pending_results.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (TURNAROUND + 8) @(posedge clk);
    endtask

    task automatic write_timeout(logic [15:0] v);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.payload.end_timeout_seconds <= v;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        model.end_timeout = v;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic table_req_t make_cmd(cmd_t c);
        table_req_t r;
        r = '0;
        r.cmd = c;
        // junk in the key fields: they must not matter outside an add
        if ($urandom_range(0, 1))
        begin
            r.rec_seconds = $urandom;
            r.rec_serial = $urandom;
            r.rec_node = 16'($urandom);
        end
        return r;
    endfunction

    function automatic table_req_t make_add(logic [31:0] sec, logic [9:0] ms,
                                            logic [31:0] ser, logic [15:0] node,
                                            logic fin, logic eoe, logic enr);
        table_req_t r;
        r.cmd = CMD_ADD;
        r.rec_seconds = sec;
        r.rec_millis = ms;
        r.rec_serial = ser;
        r.rec_node = node;
        r.rec_is_final = fin;
        r.rec_is_eoe = eoe;
        r.rec_enriched = enr;
        return r;
    endfunction

    // a plausible record near the running time, keys drawn from small pools; one in ten fully random
    function automatic table_req_t random_add();
        table_req_t r;
        int k;
        k = $urandom_range(0, 99);
        r = make_add(now_sec - $urandom_range(0, 1), 10'($urandom_range(0, 3) * 333),
                     32'd100 + $urandom_range(0, 6), 16'($urandom_range(0, 2)),
                     $urandom_range(0, 5) == 0, $urandom_range(0, 7) == 0,
                     1'($urandom_range(0, 1)));
        if (k < 10)
        begin
            r.rec_seconds = $urandom;
            r.rec_millis = 10'($urandom_range(0, 999));
            r.rec_serial = $urandom;
            r.rec_node = 16'($urandom);
        end
        return r;
    endfunction

    task automatic random_phase(int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            if ($urandom_range(0, 3) == 0) now_sec += $urandom_range(0, 3);
            if (k < 66) send_request(random_add(), pick_gap());
            else if (k < 90) send_request(make_cmd(CMD_FETCH), pick_gap());
            else if (k < 93) send_request(make_cmd(CMD_TERMINATE), pick_gap());
            else send_request(make_cmd(CMD_COMPLETE), pick_gap());
        end
    endtask

    initial
    begin
        model = new();
        model.clear();
        rst_n = 1'b0;
        cycle_count = 0;
        requests_sent = 0;
        now_sec = 32'd1000;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.payload = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, eoe drop, append, final first record, fetches
        send_request(make_cmd(CMD_FETCH), 0);
        send_request(make_add(32'd0, 10'd0, 32'd0, 16'd0, 1'b0, 1'b1, 1'b0), 0);
        send_request(make_add(32'd0, 10'd0, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0), 0);
        send_request(make_add(32'd0, 10'd0, 32'd0, 16'd0, 1'b0, 1'b1, 1'b1), 1);
        send_request(make_add(32'hFFFF_FFFF, 10'd999, 32'hFFFF_FFFF, 16'hFFFF,
                              1'b1, 1'b0, 1'b1), 0);
        send_request(make_add(32'hFFFF_FFFF, 10'd999, 32'hFFFF_FFFF, 16'hFFFF,
                              1'b0, 1'b0, 1'b0), 0);
        send_request(make_add(32'd5, 10'd512, 32'd7, 16'd3, 1'b0, 1'b0, 1'b0), 0);
        send_request(make_add(32'd5, 10'd512, 32'd7, 16'd4, 1'b0, 1'b0, 1'b0), 2);
        send_request(make_cmd(CMD_FETCH), 0);
        send_request(make_add(32'd5, 10'd512, 32'd7, 16'd3, 1'b1, 1'b0, 1'b0), 0);
        send_request(make_cmd(CMD_COMPLETE), 0);
        send_request(make_cmd(CMD_FETCH), 0);
        send_request(make_cmd(CMD_FETCH), 0);
        send_request(make_cmd(CMD_TERMINATE), 0);
        for (int i = 0; i < 5; i++) send_request(make_cmd(CMD_FETCH), 0);

        // fill the table beyond capacity without any timeout firing
        write_timeout(16'hFFFF);
        for (int i = 0; i < NSLOT + 3; i++)
            send_request(make_add(32'd10, 10'(i), 32'd1, 16'd9, 1'b0, 1'b0, 1'b0),
                         pick_gap());
        send_request(make_cmd(CMD_TERMINATE), 0);
        for (int i = 0; i < NSLOT + 1; i++) send_request(make_cmd(CMD_FETCH), pick_gap());

        // one key added repeatedly under timeout 0 (each new slot times out in its own sweep), then fetches
        write_timeout(16'd0);
        for (int i = 0; i < 270; i++)
            send_request(make_add(32'd77, 10'd1, 32'd2, 16'd0, 1'b0, 1'b0, 1'(i == 100)), 0);
        send_request(make_add(32'd78, 10'd1, 32'd2, 16'd0, 1'b0, 1'b0, 1'b0), 0);
        for (int i = 0; i < 3; i++) send_request(make_cmd(CMD_FETCH), 0);

        // random phases under several timeout settings
        write_timeout(16'd2);
        random_phase(300);
        // long receiver stall while requests keep coming
        -> hold_start;
        random_phase(40);
        write_timeout(16'd1);
        random_phase(300);
        write_timeout(16'($urandom_range(3, 20)));
        random_phase(300);
        write_timeout(16'hFFFF);
        random_phase(150);
        send_request(make_cmd(CMD_TERMINATE), 0);
        write_timeout(16'd0);
        random_phase(300);
        drain();
        for (int i = 0; i < NSLOT + 2; i++) send_request(make_cmd(CMD_FETCH), 0);

        drain();
        $display("%0d requests, %0d results, %0d releases, %0d table-full answers",
                 requests_sent, model.results_seen, model.releases, model.fulls);
        $display("timeouts 0, 1, 2, random and 65535 exercised; %0d results left over",
                 model.pending_results.size());
        if (model.mismatches == 0 && model.pending_results.size() == 0)
            $display("event_grouping_reorder_table_top: match");
        else
            $display("event_grouping_reorder_table_top: mismatch");
        $finish;
    end
endmodule
